/* hw/rtl/sfr_pkg.sv */
// ============================================================================
// sfr_pkg - shared types and codes of the checked frame receiver
// Result status codes, register indexes and the replay request bundle.
// ============================================================================
`default_nettype none

package sfr_pkg;

    // Result status codes
    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Configuration register indexes
    localparam logic REG_HEAD_BYTE = 1'b0;
    localparam logic REG_ID_LIMIT  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] HEAD_BYTE_RESET = 8'd90;
    localparam logic [7:0] ID_LIMIT_RESET  = 8'd8;

    // Request from the parser to the replay unit: one run of results
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] msg_id;
        logic [7:0] length;
    } sfr_req_t;

endpackage

`default_nettype wire

/* hw/rtl/sum_checked_frame_receiver.sv */
// ============================================================================
// sum_checked_frame_receiver - additive-checksum serial frame receiver
// Parses head/id/length/payload/check frames from a byte stream and replays
// good payloads as a run of results.
// ============================================================================
// Header and payload bytes are taken one per cycle. A byte that ends a frame
// with a result (check byte, or a length above MAX_PAYLOAD) pauses the input
// while its results are produced: a single status result, or, for a good
// frame, the payload bytes read back through the payload store's registered
// read port, one entry per cycle while the sink does not stall.
// The last result may still wait on m_tready while new bytes are accepted.
// Payload store entries need no clearing after reset.
`default_nettype none

module sum_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wr_data,
    // received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [7:0] msg_id, [15:8] frame_length,
                                        // [21:16] byte_index, [29:22] payload_byte
    output logic      [1:0]  m_tuser,   // [1:0] status
    output logic             m_tlast
);
    import sfr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    sfr_req_t      req;
    logic          s_accept;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    assign s_accept = s_tvalid && s_tready;

    sfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (s_accept),
        .rx_byte     (s_tdata),
        .req_o       (req),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfr_replay #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_replay (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_i    (req),
        .ready_o  (s_tready),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/sfr_ram.sv */
// ============================================================================
// sfr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/sfr_parser.sv */
// ============================================================================
// sfr_parser - frame header parser and payload writer
// Hunts for the head byte, checks id and length, keeps the running sum,
// writes payload bytes into the store and raises a replay request.
// ============================================================================
`default_nettype none

module sfr_parser #(
    parameter int MAX_PAYLOAD = 64,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [7:0]        cfg_wr_data,
    input  wire logic              byte_valid,
    input  wire logic [7:0]        rx_byte,
    output sfr_pkg::sfr_req_t      req_o,
    output logic                   wr_en,
    output logic      [AW-1:0]     wr_addr,
    output logic      [7:0]        wr_data
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    phase_t     phase_reg, phase_next;
    logic [7:0] head_byte_reg, id_limit_reg;
    logic [7:0] cur_id_reg, cur_id_next;
    logic [7:0] cur_length_reg, cur_length_next;
    logic [6:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    sfr_req_t   req;

    always_comb begin
        phase_next      = phase_reg;
        cur_id_next     = cur_id_reg;
        cur_length_next = cur_length_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        req             = '0;
        wr_en           = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_ID: begin
                    if (rx_byte < id_limit_reg) begin
                        cur_id_next = rx_byte;
                        sum_next    = sum_reg + rx_byte;
                        phase_next  = PH_LEN;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    cur_length_next = rx_byte;
                    sum_next        = sum_reg + rx_byte;
                    if (rx_byte > MAX_LEN) begin
                        req.valid  = 1'b1;
                        req.status = ST_TOO_LONG;
                        req.msg_id = cur_id_reg;
                        req.length = rx_byte;
                        phase_next = PH_HUNT;
                    end else if (rx_byte == 8'd0) begin
                        phase_next = PH_CHECK;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 7'd1;
                    sum_next   = sum_reg + rx_byte;
                    if ({1'b0, count_next} >= cur_length_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_HUNT;
                    req.valid  = 1'b1;
                    req.msg_id = cur_id_reg;
                    req.length = cur_length_reg;
                    if (sum_reg != rx_byte) begin
                        req.status = ST_MISMATCH;
                    end else if (cur_length_reg == 8'd0) begin
                        req.status = ST_EMPTY;
                    end else begin
                        req.status = ST_PAYLOAD;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (rx_byte == head_byte_reg) begin
                        cur_id_next     = 8'd0;
                        cur_length_next = 8'd0;
                        count_next      = 7'd0;
                        sum_next        = rx_byte;
                        phase_next      = PH_ID;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            head_byte_reg  <= HEAD_BYTE_RESET;
            id_limit_reg   <= ID_LIMIT_RESET;
            cur_id_reg     <= 8'd0;
            cur_length_reg <= 8'd0;
            count_reg      <= 7'd0;
            sum_reg        <= 8'd0;
        end else begin
            phase_reg      <= phase_next;
            cur_id_reg     <= cur_id_next;
            cur_length_reg <= cur_length_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_HEAD_BYTE: head_byte_reg <= cfg_wr_data;
                    REG_ID_LIMIT:  id_limit_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    assign req_o   = req;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = rx_byte;

`ifndef SYNTHESIS
    // payload phase only runs for a length that fits the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> (cur_length_reg != 8'd0 && cur_length_reg <= MAX_LEN))
        else $error("payload phase with illegal length");

    // every store write lands inside the declared length
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> {1'b0, count_reg} < cur_length_reg)
        else $error("payload write beyond frame length");

    // a replay request ends the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid |=> phase_reg == PH_HUNT)
        else $error("request without return to hunting");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sfr_replay.sv */
// ============================================================================
// sfr_replay - result sequencer and output register
// Reads the payload store back one entry per cycle on a good frame while the
// output is not stalled, or emits one status result; drives the master stream.
// ============================================================================
`default_nettype none

module sfr_replay #(
    parameter int MAX_PAYLOAD = 64,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sfr_pkg::sfr_req_t req_i,
    output logic                   ready_o,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    input  wire logic [7:0]        rd_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [31:0]       m_tdata,
    output logic      [1:0]        m_tuser,
    output logic                   m_tlast
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        RP_IDLE,
        RP_ONE,
        RP_READ,
        RP_EMIT
    } rp_state_t;

    rp_state_t  state_reg;
    logic [1:0] status_reg;
    logic [7:0] msg_id_reg, length_reg;
    logic [5:0] idx_reg;
    logic [5:0] idx_inc;
    logic       out_free, run_last, out_load;
    logic       m_tvalid_reg, m_tlast_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free && (state_reg inside {RP_ONE, RP_EMIT});
    assign idx_inc  = idx_reg + 6'd1;
    assign run_last = ({2'b00, idx_reg} + 8'd1) == length_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        case (state_reg)
            RP_READ: rd_en = 1'b1;
            RP_EMIT: begin
                // prefetch the next entry while the current one is taken
                rd_en   = out_free && !run_last;
                rd_addr = idx_inc[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= RP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                RP_IDLE: begin
                    if (req_i.valid) begin
                        status_reg <= req_i.status;
                        msg_id_reg <= req_i.msg_id;
                        length_reg <= req_i.length;
                        idx_reg    <= 6'd0;
                        state_reg  <= (req_i.status == ST_PAYLOAD) ? RP_READ : RP_ONE;
                    end
                end
                RP_ONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {2'b00, 8'd0, 6'd0, length_reg, msg_id_reg};
                        m_tuser_reg  <= status_reg;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= RP_IDLE;
                    end
                end
                RP_READ: state_reg <= RP_EMIT;
                RP_EMIT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {2'b00, rd_data, idx_reg, length_reg, msg_id_reg};
                        m_tuser_reg  <= ST_PAYLOAD;
                        m_tlast_reg  <= run_last;
                        if (run_last) begin
                            state_reg <= RP_IDLE;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end
                end
                default: state_reg <= RP_IDLE;
            endcase
        end
    end

    assign ready_o  = (state_reg == RP_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // a request never arrives while a run is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_i.valid |-> state_reg == RP_IDLE)
        else $error("request while replay busy");

    // the replay index stays below the frame length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RP_READ || state_reg == RP_EMIT) |->
            ({2'b00, idx_reg} < length_reg && length_reg <= 8'(MAX_PAYLOAD)))
        else $error("replay index out of range");

    // a non-final payload result keeps the run going
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RP_EMIT && out_free && !run_last) |=> state_reg == RP_EMIT)
        else $error("payload run cut short");
`endif

endmodule

`default_nettype wire

/* verif/sum_checked_frame_receiver_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// sum_checked_frame_receiver_test - self-checking bench of the frame receiver
// Streams framed and broken byte sequences under random source bursts and
// sink stalls, predicts every result from a model of the frame parser kept
// in a scoreboard, and compares each result field by field in order.
// ============================================================================

module sum_checked_frame_receiver_test;

    import sfr_pkg::*;

    localparam int FRAME_CAP   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;

    typedef enum logic [2:0] {
        PARSE_HUNT,
        PARSE_ID,
        PARSE_LEN,
        PARSE_DATA,
        PARSE_CHECK
    } parse_phase_t;

    typedef struct {
        logic [1:0] status;
        logic [7:0] msg_id;
        logic [7:0] frame_length;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } frame_result_t;

    // Frame parser prediction and in-order result comparison
    class frame_scoreboard;
        logic [7:0]    head_byte;
        logic [7:0]    id_limit;
        parse_phase_t  phase;
        logic [7:0]    cur_id;
        logic [7:0]    cur_len;
        logic [6:0]    rcv_count;
        logic [7:0]    sum;
        logic [7:0]    payload_mem [FRAME_CAP];
        frame_result_t expected_q [$];
        int            errors;

        function new();
            head_byte = HEAD_BYTE_RESET;
            id_limit  = ID_LIMIT_RESET;
            phase     = PARSE_HUNT;
            cur_id    = '0;
            cur_len   = '0;
            rcv_count = '0;
            sum       = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == REG_HEAD_BYTE) begin
                head_byte = value;
            end else begin
                id_limit = value;
            end
        endfunction

        function void report(string msg);
            $display("%0t ns  MISMATCH: %s", $realtime, msg);
            errors++;
        endfunction

        function void push_result(logic [1:0] status, logic [5:0] idx, logic [7:0] value,
                                  logic last);
            frame_result_t r;
            r.status       = status;
            r.msg_id       = cur_id;
            r.frame_length = cur_len;
            r.byte_index   = idx;
            r.payload_byte = value;
            r.last         = last;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                PARSE_ID: begin
                    if (b < id_limit) begin
                        cur_id = b;
                        sum    = sum + b;
                        phase  = PARSE_LEN;
                    end else begin
                        phase = PARSE_HUNT;
                    end
                end
                PARSE_LEN: begin
                    cur_len = b;
                    sum     = sum + b;
                    if (b > FRAME_CAP) begin
                        push_result(ST_TOO_LONG, '0, '0, 1'b1);
                        phase = PARSE_HUNT;
                    end else begin
                        phase = (b == 0) ? PARSE_CHECK : PARSE_DATA;
                    end
                end
                PARSE_DATA: begin
                    payload_mem[rcv_count[5:0]] = b;
                    rcv_count = rcv_count + 1'b1;
                    sum       = sum + b;
                    if (rcv_count >= cur_len) begin
                        phase = PARSE_CHECK;
                    end
                end
                PARSE_CHECK: begin
                    phase = PARSE_HUNT;
                    if (sum != b) begin
                        push_result(ST_MISMATCH, '0, '0, 1'b1);
                    end else if (cur_len == 0) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < cur_len; i++) begin
                            push_result(ST_PAYLOAD, 6'(i), payload_mem[i],
                                        (i + 1 == cur_len));
                        end
                    end
                end
                default: begin
                    phase = PARSE_HUNT;
                    if (b == head_byte) begin
                        cur_id    = '0;
                        cur_len   = '0;
                        rcv_count = '0;
                        sum       = b;
                        phase     = PARSE_ID;
                    end
                end
            endcase
        endfunction

        function void field_check(string name, int got, int want);
            if (got != want) begin
                report($sformatf("%s got %0d, want %0d", name, got, want));
            end
        endfunction

        function void check_result(logic [1:0] status, logic [31:0] data, logic last);
            frame_result_t w;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected, status %0d data %h",
                                 status, data));
                return;
            end
            w = expected_q.pop_front();
            field_check("status",       status,        w.status);
            field_check("msg_id",       data[7:0],     w.msg_id);
            field_check("frame_length", data[15:8],    w.frame_length);
            field_check("byte_index",   data[21:16],   w.byte_index);
            field_check("payload_byte", data[29:22],   w.payload_byte);
            field_check("last",         last,          w.last);
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_addr    = REG_HEAD_BYTE;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    frame_scoreboard sb;
    logic [7:0]      tx_bytes [$];
    logic [7:0]      cur_head  = HEAD_BYTE_RESET;
    logic [7:0]      cur_limit = ID_LIMIT_RESET;
    int              cycle_count = 0;
    int              stall_left  = 0;
    int              stall_mode  = 0;

    sum_checked_frame_receiver #(
        .MAX_PAYLOAD(FRAME_CAP)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Sink: switch at random between stall patterns
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (cycle_count % 3 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata, m_tlast);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sum_checked_frame_receiver_test: done, errors");
            $finish;
        end
    end

    task automatic configure(input logic [7:0] head, input logic [7:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_HEAD_BYTE;
        cfg_wr_data <= head;
        @(posedge aclk);
        cfg_addr    <= REG_ID_LIMIT;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_reg(REG_HEAD_BYTE, head);
        sb.set_reg(REG_ID_LIMIT, limit);
        cur_head  = head;
        cur_limit = limit;
    endtask

    function automatic logic [7:0] valid_id();
        if (cur_limit == 0) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(0, cur_limit - 1));
    endfunction

    function automatic void queue_frame(input logic [7:0] id, input logic [7:0] len,
                                        input bit bad_check);
        logic [7:0] total;
        logic [7:0] b;
        total = cur_head + id + len;
        tx_bytes.push_back(cur_head);
        tx_bytes.push_back(id);
        tx_bytes.push_back(len);
        if (len > FRAME_CAP) begin
            return;
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            total = total + b;
            tx_bytes.push_back(b);
        end
        tx_bytes.push_back(bad_check ? (total ^ 8'($urandom_range(1, 255))) : total);
    endfunction

    // Mostly well-formed frames, with too-long, wrong-id, cut-off and noise mixed in
    function automatic void queue_random(input int n_items);
        int pick;
        while (tx_bytes.size() < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(valid_id(),
                            ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, FRAME_CAP))
                                                        : 8'($urandom_range(0, 6)),
                            $urandom_range(0, 9) == 0);
            end else if (pick < 78) begin
                queue_frame(valid_id(), 8'($urandom_range(FRAME_CAP + 1, 255)), 1'b0);
            end else if (pick < 85) begin
                tx_bytes.push_back(cur_head);
                tx_bytes.push_back(8'($urandom_range(cur_limit, 255)));
            end else if (pick < 92) begin
                tx_bytes.push_back(cur_head);
                tx_bytes.push_back(valid_id());
                tx_bytes.push_back(8'($urandom_range(2, 10)));
                tx_bytes.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    // Send the byte queue in bursts; optionally hold once until all results are out
    task automatic send_bytes(input bit hold_midway);
        int  sent;
        int  burst_left;
        int  gap_left;
        bit  held;
        sent       = 0;
        burst_left = $urandom_range(1, 16);
        gap_left   = 0;
        held       = 1'b0;
        while (sent < tx_bytes.size()) begin
            if (hold_midway && !held && sent >= tx_bytes.size() / 2) begin
                held = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0) @(posedge aclk);
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
                @(posedge aclk);
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= tx_bytes[sent];
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                sb.note_byte(tx_bytes[sent]);
                sent++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= 1'b0;
        tx_bytes.delete();
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values
        queue_frame(8'd0, 8'd0, 1'b0);
        tx_bytes.push_back(cur_head);
        tx_bytes.push_back(8'd7);
        tx_bytes.push_back(8'd1);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(cur_head + 8'd7 + 8'd1 + 8'hFF);
        // rejected id equal to the head value must not restart a frame
        tx_bytes.push_back(cur_head);
        tx_bytes.push_back(cur_head);
        tx_bytes.push_back(8'd0);
        tx_bytes.push_back(8'd0);
        tx_bytes.push_back(cur_head);
        queue_frame(8'd3, 8'd0, 1'b0);
        queue_frame(8'd2, 8'd0, 1'b1);
        queue_frame(8'd1, 8'(FRAME_CAP + 1), 1'b0);
        queue_frame(8'd5, 8'hFF, 1'b0);
        send_bytes(1'b0);
        drain();

        configure(8'h00, 8'hFF);
        queue_frame(8'hFE, 8'(FRAME_CAP), 1'b0);
        queue_random(76);
        send_bytes(1'b0);
        drain();

        configure(8'hFF, 8'h01);
        queue_random(16);
        send_bytes(1'b0);
        drain();

        configure(8'($urandom), 8'($urandom_range(1, 255)));
        queue_random(20);
        send_bytes(1'b1);
        drain();

        // zero id limit: nothing gets past the id byte
        configure(8'($urandom), 8'h00);
        queue_random(8);
        send_bytes(1'b0);
        drain();

        configure(HEAD_BYTE_RESET, ID_LIMIT_RESET);
        queue_random(10);
        send_bytes(1'b0);
        drain();

        if (sb.errors == 0) begin
            $display("sum_checked_frame_receiver_test: done, clean");
        end else begin
            $display("sum_checked_frame_receiver_test: done, errors");
        end
        $finish;
    end

endmodule
